// ===== src/plap_pkg.sv =====
// ============================================================================
// plap_pkg
// Shared types and constants for the per-key adaptive low-pass core.
// ============================================================================
package plap_pkg;

    localparam int KEY_IDX_W  = 7;
    localparam int SAMPLE_W   = 12;
    localparam int VALUE_W    = 16;
    localparam int SPAN_W     = 12;
    localparam int GAIN_W     = 9;
    localparam int COUNT_W    = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [GAIN_W-1:0]  GAIN_ONE  = 9'd256;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;

    localparam logic [CFG_IDX_W-1:0] REG_STEP_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RUN_LENGTH     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_GAIN      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RUN_GAIN       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE_GAIN   = 3'd4;

    localparam logic [SAMPLE_W-1:0] RST_STEP_THRESHOLD = 12'd35;
    localparam logic [COUNT_W-1:0]  RST_RUN_LENGTH     = 4'd2;
    localparam logic [GAIN_W-1:0]   RST_BASE_GAIN      = 9'd38;
    localparam logic [GAIN_W-1:0]   RST_RUN_GAIN       = 9'd115;
    localparam logic [GAIN_W-1:0]   RST_REVERSE_GAIN   = 9'd51;

    typedef struct packed {
        logic [SAMPLE_W-1:0] step_threshold;
        logic [COUNT_W-1:0]  run_length;
        logic [GAIN_W-1:0]   base_gain;
        logic [GAIN_W-1:0]   run_gain;
        logic [GAIN_W-1:0]   reverse_gain;
    } cfg_t;

    typedef struct packed {
        logic               rising;
        logic [COUNT_W-1:0] run_count;
    } key_state_t;

    function automatic logic [GAIN_W-1:0] sat_gain(input logic [GAIN_W-1:0] g);
        return (g > GAIN_ONE) ? GAIN_ONE : g;
    endfunction

endpackage

// ===== src/plap_state_mem.sv =====
// ============================================================================
// plap_state_mem
// Per-key state memory with registered read data and a valid bit per entry.
// ============================================================================
module plap_state_mem
    import plap_pkg::*;
#(
    parameter int KEYS  = 128,
    parameter int KEY_W = 7
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             rd_en,
    input  logic [KEY_W-1:0] rd_addr,
    output key_state_t       rd_state,
    input  logic             wr_en,
    input  logic [KEY_W-1:0] wr_addr,
    input  key_state_t       wr_state
);

    key_state_t        mem [KEYS];
    logic [KEYS-1:0]   vld_reg;
    key_state_t        rd_data_reg;
    logic              rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_state;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_state = rd_vld_reg ? rd_data_reg : key_state_t'('0);

endmodule

// ===== src/plap_gain.sv =====
// ============================================================================
// plap_gain
// Gain selection and next per-key direction and run count.
// ============================================================================
module plap_gain
    import plap_pkg::*;
(
    input  cfg_t                cfg,
    input  logic [SAMPLE_W-1:0] new_sample,
    input  logic [VALUE_W-1:0]  prev_value,
    input  logic [SPAN_W-1:0]   key_span,
    input  logic                key_ok,
    input  key_state_t          cur_state,
    output logic [GAIN_W-1:0]   gain,
    output key_state_t          next_state
);

    logic [VALUE_W-1:0]  s16;
    logic                up;
    logic [VALUE_W-1:0]  mag;
    logic [SAMPLE_W-1:0] udif;
    logic [SPAN_W-2:0]   half;
    logic                big;
    logic                dir;
    key_state_t          old;
    logic [COUNT_W-1:0]  cnt;

    always_comb begin
        s16  = {new_sample, 4'b0000};
        up   = s16 > prev_value;
        mag  = up ? (s16 - prev_value) : (prev_value - s16);
        udif = mag[VALUE_W-1:4];
        dir  = up && (udif != '0);
        half = key_span[SPAN_W-1:1];
        big  = (half == '0) || (udif >= {1'b0, half});
        old  = key_ok ? cur_state : key_state_t'('0);
        cnt  = old.run_count;
        if (dir != old.rising) begin
            cnt  = '0;
            gain = big ? GAIN_ONE : sat_gain(cfg.reverse_gain);
        end else begin
            if ((udif > cfg.step_threshold) && (cnt < COUNT_MAX)) begin
                cnt = cnt + 1'b1;
            end
            if (big) begin
                gain = GAIN_ONE;
            end else if (cnt >= cfg.run_length) begin
                gain = sat_gain(cfg.run_gain);
            end else begin
                gain = sat_gain(cfg.base_gain);
            end
        end
        next_state.rising    = dir;
        next_state.run_count = cnt;
    end

endmodule

// ===== src/per_key_adaptive_low_pass_core.sv =====
// ============================================================================
// per_key_adaptive_low_pass_core
// Per-key adaptive first-order low-pass with direction and run tracking.
// ============================================================================
// A request is taken, its key's direction bit and run count are read from the
// state memory, the gain is chosen and the state written back in the next
// cycle, and the rounded blend new*g + prev*(1-g) is formed in the cycle after
// and loaded into the output register once it is free. No request is taken in
// the gain state: the read-modify-write of the state memory sets this, and a
// new request enters in the cycle that finishes the previous one. A request
// passes the gain and mix states before m_tvalid. The result register lets the
// next request enter while a result still waits for m_tready. Keys at or above
// KEYS read as falling with a run count of zero and leave the state untouched.
module per_key_adaptive_low_pass_core
    import plap_pkg::*;
#(
    parameter int KEYS = 128
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // [6:0] key_index, [18:7] new_sample, [34:19] prev_value, [46:35] key_span
    input  logic [47:0]           s_tdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [15:0] filtered_value, [24:16] gain_used
    output logic [31:0]           m_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int KEY_W = (KEYS > 1) ? $clog2(KEYS) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GAIN,
        ST_MIX
    } state_t;

    state_t              state_reg, state_next;
    cfg_t                cfg_reg;
    logic [KEY_IDX_W-1:0] key_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [VALUE_W-1:0]  prev_reg;
    logic [SPAN_W-1:0]   span_reg;
    logic [GAIN_W-1:0]   gain_reg;
    logic [VALUE_W-1:0]  out_value_reg;
    logic [GAIN_W-1:0]   out_gain_reg;
    logic                m_valid_reg, m_valid_next;

    logic                s_accept;
    logic                out_free;
    logic                key_ok;
    key_state_t          rd_state;
    key_state_t          wr_state;
    logic [GAIN_W-1:0]   gain;
    logic signed [VALUE_W:0]   diff;
    logic signed [VALUE_W+GAIN_W+1:0] prod;
    logic signed [VALUE_W+GAIN_W+3:0] acc;

    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) || ((state_reg == ST_MIX) && out_free);
    assign s_accept  = s_tvalid && s_tready;
    assign key_ok    = 32'(key_reg) < KEYS;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.step_threshold <= RST_STEP_THRESHOLD;
            cfg_reg.run_length     <= RST_RUN_LENGTH;
            cfg_reg.base_gain      <= RST_BASE_GAIN;
            cfg_reg.run_gain       <= RST_RUN_GAIN;
            cfg_reg.reverse_gain   <= RST_REVERSE_GAIN;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_STEP_THRESHOLD: cfg_reg.step_threshold <= cfg_data;
                REG_RUN_LENGTH:     cfg_reg.run_length     <= cfg_data[COUNT_W-1:0];
                REG_BASE_GAIN:      cfg_reg.base_gain      <= cfg_data[GAIN_W-1:0];
                REG_RUN_GAIN:       cfg_reg.run_gain       <= cfg_data[GAIN_W-1:0];
                REG_REVERSE_GAIN:   cfg_reg.reverse_gain   <= cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    plap_state_mem #(
        .KEYS  (KEYS),
        .KEY_W (KEY_W)
    ) u_state_mem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (s_accept),
        .rd_addr  (KEY_W'(s_tdata[KEY_IDX_W-1:0])),
        .rd_state (rd_state),
        .wr_en    ((state_reg == ST_GAIN) && key_ok),
        .wr_addr  (KEY_W'(key_reg)),
        .wr_state (wr_state)
    );

    plap_gain u_gain (
        .cfg        (cfg_reg),
        .new_sample (sample_reg),
        .prev_value (prev_reg),
        .key_span   (span_reg),
        .key_ok     (key_ok),
        .cur_state  (rd_state),
        .gain       (gain),
        .next_state (wr_state)
    );

    always_comb begin
        diff = $signed({1'b0, sample_reg, 4'b0000}) - $signed({1'b0, prev_reg});
        prod = (VALUE_W+GAIN_W+2)'(diff) * (VALUE_W+GAIN_W+2)'($signed({1'b0, gain_reg}));
        acc  = $signed({5'b00000, prev_reg, 8'h80}) + (VALUE_W+GAIN_W+4)'(prod);
    end

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_GAIN;
                end
            end
            ST_GAIN: begin
                state_next = ST_MIX;
            end
            ST_MIX: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = s_accept ? ST_GAIN : ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        if (s_accept) begin
            key_reg    <= s_tdata[6:0];
            sample_reg <= s_tdata[18:7];
            prev_reg   <= s_tdata[34:19];
            span_reg   <= s_tdata[46:35];
        end
        if (state_reg == ST_GAIN) begin
            gain_reg <= gain;
        end
        if ((state_reg == ST_MIX) && out_free) begin
            out_value_reg <= acc[VALUE_W+7:8];
            out_gain_reg  <= gain_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, out_gain_reg, out_value_reg};

    a_accept_to_gain: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg == ST_GAIN))
        else $error("accepted request did not enter gain stage");

    a_gain_to_mix: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_GAIN) |=> (state_reg == ST_MIX))
        else $error("gain stage not followed by mix stage");

    a_gain_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MIX) |-> (gain_reg <= GAIN_ONE))
        else $error("gain above unity");

    a_load_from_mix: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_MIX))
        else $error("result loaded outside mix stage");

endmodule
